// ===== rtl/lbp3_pkg.sv =====
// Shared types, constants and register codes for the 3x3 LBP stream core.
package lbp3_pkg;

    // Default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // Configuration registers
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 12'd480;

    // Result item
    localparam int PATTERN_W = 8;

    typedef struct packed {
        logic                 frame_last;
        logic [PATTERN_W-1:0] pattern;
    } t_code;

endpackage

// ===== rtl/lbp3_line_mem.sv =====
// Combined line store memory (two rows per entry) with write-to-read forwarding.
module lbp3_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd;

    // Storage array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Read and write of the same entry at one edge: take the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

// ===== rtl/lbp3_window.sv =====
// 3x3 neighborhood registers and LBP code compare.
module lbp3_window import lbp3_pkg::*; #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [PIXEL_BITS-1:0] i_top,
    input  logic [PIXEL_BITS-1:0] i_mid,
    input  logic [PIXEL_BITS-1:0] i_bot,
    output logic [PATTERN_W-1:0]  o_pattern
);

    // Two held columns, row 0 top .. row 2 bottom; the new column arrives on the inputs
    logic [PIXEL_BITS-1:0] r_c1 [3];
    logic [PIXEL_BITS-1:0] r_c2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_c1[r] <= '0;
                r_c2[r] <= '0;
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_c1[r] <= r_c2[r];
            end
            r_c2[0] <= i_top;
            r_c2[1] <= i_mid;
            r_c2[2] <= i_bot;
        end
    end

    // At a shift: left = r_c1, center = r_c2, right = inputs
    logic [PIXEL_BITS-1:0] ctr;
    assign ctr = r_c2[1];

    always_comb begin
        o_pattern[7] = (r_c1[0] >= ctr);
        o_pattern[6] = (r_c2[0] >= ctr);
        o_pattern[5] = (i_top   >= ctr);
        o_pattern[4] = (i_mid   >= ctr);
        o_pattern[3] = (i_bot   >= ctr);
        o_pattern[2] = (r_c2[2] >= ctr);
        o_pattern[1] = (r_c1[2] >= ctr);
        o_pattern[0] = (r_c1[1] >= ctr);
    end

endmodule

// ===== rtl/lbp3_out_fifo.sv =====
// Two-entry output queue that decouples the pipeline from the result consumer.
module lbp3_out_fifo import lbp3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_code i_data,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_code o_data
);

    t_code      r_buf [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    // A push is safe unless both entries are held and none leaves this cycle
    assign o_room  = (r_cnt != 2'd2) || i_ready;
    assign o_data  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/lbp_3x3_code_stream_core.sv =====
// 3x3 local binary pattern stream core: top level with counters and pipeline control.
//
// Pixels enter in raster order, one per clock when the result side keeps up; a
// pixel flagged by tuser starts a new frame. Each pixel takes one read-modify-
// write of the line memory (one entry holds the two stored rows of a column),
// read at acceptance and written back from stage 1, with forwarding when a
// frame restart hits the column just written. A code for an interior pixel
// is formed as the pixel that completes its neighborhood leaves stage 1 and
// leaves through a two-entry output queue; tlast marks the last code of a frame.
// The input keeps accepting while one result waits unclaimed. The line memory
// needs no clearing after reset: border rows and columns never produce codes.
// Geometry registers are meant to be written between frames; frame_cols is
// clamped to 3..MAX_WIDTH and frame_rows to at least 3.
module lbp_3x3_code_stream_core import lbp3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]               i_cfg_wdata,
    // pixel stream in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     i_s_axis_tdata,  // pixel
    input  logic                                i_s_axis_tuser,  // frame_start
    // code stream out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [PATTERN_W-1:0]                o_m_axis_tdata,  // pattern
    output logic                                o_m_axis_tlast   // frame_last
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CLW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

    // Geometry registers
    logic [COLS_W-1:0] r_frame_cols;
    logic [ROWS_W-1:0] r_frame_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols <= COLS_RESET;
            r_frame_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_COLS: r_frame_cols <= i_cfg_wdata[COLS_W-1:0];
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_wdata[ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamped geometry, as last column and last row
    logic [CLW-1:0]    cols_ext;
    logic [CLW-1:0]    cols_lim;
    logic [CW-1:0]     cols_m1;
    logic [ROWS_W-1:0] rows_lim;
    logic [ROWS_W-1:0] rows_m1;

    always_comb begin
        cols_ext = CLW'(r_frame_cols);
        if (cols_ext < CLW'(3)) begin
            cols_lim = CLW'(3);
        end else if (cols_ext > CLW'(MAX_WIDTH)) begin
            cols_lim = CLW'(MAX_WIDTH);
        end else begin
            cols_lim = cols_ext;
        end
        cols_m1  = CW'(cols_lim - CLW'(1));
        rows_lim = (r_frame_rows < ROWS_W'(3)) ? ROWS_W'(3) : r_frame_rows;
        rows_m1  = rows_lim - ROWS_W'(1);
    end

    // Pipeline advance: the output queue can take what stage 1 holds
    logic fifo_room;
    logic en;
    logic accept;

    assign en              = fifo_room;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    // Stage 0: position of the incoming pixel
    logic [CW-1:0]     r_col_count;
    logic [ROWS_W-1:0] r_row_count;
    logic [CW-1:0]     col_raw;
    logic [ROWS_W-1:0] row_raw;
    logic [CW-1:0]     col;
    logic [ROWS_W-1:0] row;
    logic              row_end;
    logic              frame_end;
    logic              emit;
    logic [CW-1:0]     n_col_count;
    logic [ROWS_W-1:0] n_row_count;

    always_comb begin
        col_raw   = i_s_axis_tuser ? '0 : r_col_count;
        row_raw   = i_s_axis_tuser ? '0 : r_row_count;
        col       = (col_raw > cols_m1) ? cols_m1 : col_raw;
        row       = (row_raw > rows_m1) ? rows_m1 : row_raw;
        row_end   = (col == cols_m1);
        frame_end = row_end && (row == rows_m1);
        emit      = (row >= ROWS_W'(2)) && (col >= CW'(2));
        if (row_end) begin
            n_col_count = '0;
            n_row_count = frame_end ? '0 : row + ROWS_W'(1);
        end else begin
            n_col_count = col + CW'(1);
            n_row_count = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (accept) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
        end
    end

    // Stage 1 registers
    logic                  r_s1_vld;
    logic                  r_s1_emit;
    logic                  r_s1_last;
    logic [CW-1:0]         r_s1_col;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic                  s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit;
            r_s1_last <= frame_end;
            r_s1_col  <= col;
            r_s1_px   <= i_s_axis_tdata[PIXEL_BITS-1:0];
        end
    end

    assign s1_fire = r_s1_vld && en;

    // Line memory: entry = {two rows above, one row above}
    logic [2*PIXEL_BITS-1:0] mem_rd;
    logic [PIXEL_BITS-1:0]   top;
    logic [PIXEL_BITS-1:0]   mid;

    assign top = mem_rd[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid = mem_rd[PIXEL_BITS-1:0];

    lbp3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mid, r_s1_px}),
        .o_rd_data (mem_rd)
    );

    // Window and code compare
    logic [PATTERN_W-1:0] pattern;

    lbp3_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (s1_fire),
        .i_top     (top),
        .i_mid     (mid),
        .i_bot     (r_s1_px),
        .o_pattern (pattern)
    );

    // Output queue
    t_code push_code;
    t_code out_code;
    logic  push;

    assign push                 = s1_fire && r_s1_emit;
    assign push_code.pattern    = pattern;
    assign push_code.frame_last = r_s1_last;

    lbp3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_code),
        .o_room  (fifo_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_code)
    );

    assign o_m_axis_tdata = out_code.pattern;
    assign o_m_axis_tlast = out_code.frame_last;

    // Checks
    a_accept_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted pixel did not reach stage 1");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && frame_end) |=> (r_col_count == '0 && r_row_count == '0))
        else $error("counters did not wrap at end of frame");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_col_count <= $past(cols_m1)))
        else $error("column count beyond last column");

    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && frame_end) |-> emit)
        else $error("end of frame pixel produced no code");

endmodule
